// File: rtl/bba_pkg.sv
// Package for the buddy block allocator: sizes, table entry layout,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bba_pkg;

    localparam int MAX_ORDER = 10;
    localparam int UNIT_W    = MAX_ORDER;
    localparam int UNITS     = 1 << MAX_ORDER;
    localparam int ORD_W     = 5;
    localparam int MAX_LOG   = 16;

    localparam logic [7:0] CFG_MIN_LOG = 8'd0;
    localparam logic [7:0] CFG_HDR     = 8'd1;

    localparam logic [4:0] RST_MIN_LOG = 5'd7;
    localparam logic [6:0] RST_HDR     = 7'd16;

    typedef struct packed {
        logic             head;
        logic             free;
        logic [ORD_W-1:0] order;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic prep;
        logic order;
        logic set_fail;
        logic scan_init;
        logic scan_rd;
        logic scan_chk;
        logic split;
        logic mark;
        logic rel_rd;
        logic rel_chk;
        logic bud_rd;
        logic bud_chk;
        logic rel_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic act_rel;
        logic fail;
        logic rel_ok;
        logic scan_end;
        logic found_now;
        logic split_more;
        logic rel_live;
        logic o_max;
        logic merge;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/bba_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/bba_ctrl.sv
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg.
`default_nettype none

module bba_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bba_pkg::sts_t sts,
    output bba_pkg::cmd_t      cmd
);
    import bba_pkg::*;

    typedef enum logic [14:0] {
        ST_CLEAR    = 15'b000000000000001,
        ST_IDLE     = 15'b000000000000010,
        ST_PREP     = 15'b000000000000100,
        ST_ORDER    = 15'b000000000001000,
        ST_CHECK    = 15'b000000000010000,
        ST_SCAN_RD  = 15'b000000000100000,
        ST_SCAN_CHK = 15'b000000001000000,
        ST_SPLIT    = 15'b000000010000000,
        ST_MARK     = 15'b000000100000000,
        ST_REL_RD   = 15'b000001000000000,
        ST_REL_CHK  = 15'b000010000000000,
        ST_BUD_RD   = 15'b000100000000000,
        ST_BUD_CHK  = 15'b001000000000000,
        ST_REL_WR   = 15'b010000000000000,
        ST_DONE     = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_ORDER;
            end
            ST_ORDER: begin
                cmd.order  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (sts.act_rel) begin
                    state_next = sts.rel_ok ? ST_REL_RD : ST_DONE;
                end else if (sts.fail) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd.scan_chk = 1'b1;
                if (sts.scan_end) begin
                    if (sts.found_now) begin
                        state_next = ST_SPLIT;
                    end else begin
                        cmd.set_fail = 1'b1;
                        state_next   = ST_DONE;
                    end
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SPLIT: begin
                if (sts.split_more) begin
                    cmd.split = 1'b1;
                end else begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                cmd.mark   = 1'b1;
                state_next = ST_DONE;
            end
            ST_REL_RD: begin
                cmd.rel_rd = 1'b1;
                state_next = ST_REL_CHK;
            end
            ST_REL_CHK: begin
                if (sts.rel_live) begin
                    cmd.rel_chk = 1'b1;
                    state_next  = ST_BUD_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BUD_RD: begin
                if (sts.o_max) begin
                    state_next = ST_REL_WR;
                end else begin
                    cmd.bud_rd = 1'b1;
                    state_next = ST_BUD_CHK;
                end
            end
            ST_BUD_CHK: begin
                if (sts.merge) begin
                    cmd.bud_chk = 1'b1;
                    state_next  = ST_BUD_RD;
                end else begin
                    state_next = ST_REL_WR;
                end
            end
            ST_REL_WR: begin
                cmd.rel_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bba_dp.sv
// Datapath of the buddy block allocator: config registers, request registers,
// order calculation, block table, scan/split/merge registers and result register.
// Depends on bba_pkg and bba_ram.
`default_nettype none

module bba_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bba_pkg::cmd_t cmd,
    output bba_pkg::sts_t      sts,
    input  wire logic          s_action,
    input  wire logic [30:0]   s_request_length,
    input  wire logic [31:0]   s_release_address,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_status,
    output logic [31:0]        m_granted_address,
    input  wire logic          cfg_valid,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [7:0]    cfg_data
);
    import bba_pkg::*;

    logic [4:0]        lg_reg;
    logic [6:0]        hdr_reg;
    logic              act_reg;
    logic [30:0]       len_reg;
    logic [31:0]       addr_reg;
    logic [UNIT_W-1:0] clr_cnt_reg;
    logic [32:0]       units_reg;
    logic [ORD_W-1:0]  k_reg;
    logic              fail_reg;
    logic              rel_ok_reg;
    logic [UNIT_W-1:0] u_reg;
    logic [ORD_W-1:0]  o_reg;
    logic [UNIT_W:0]   scan_reg;
    logic              found_reg;
    logic [UNIT_W-1:0] best_reg;
    logic [ORD_W-1:0]  best_ord_reg;
    logic              pend_status_reg;
    logic [31:0]       pend_addr_reg;
    logic              m_valid_reg;
    logic              m_status_reg;
    logic [31:0]       m_addr_reg;

    logic [4:0]          lg_eff;
    logic [16:0]         mask;
    logic [32:0]         units_sum;
    logic [32:0]         units_calc;
    logic [31:0]         off;
    logic [31:0]         unit32;
    logic                rel_ok_calc;
    logic [32:0]         um1;
    logic [5:0]          kk;
    entry_t              e;
    logic [ENTRY_W-1:0]  rdata;
    logic                we;
    logic [UNIT_W-1:0]   waddr;
    entry_t              wentry;
    logic [UNIT_W-1:0]   raddr;
    logic [UNIT_W:0]     scan_next;
    logic                cand;
    logic [ORD_W-1:0]    new_ord;
    logic [UNIT_W-1:0]   upper;
    logic [UNIT_W-1:0]   obit;
    logic [UNIT_W+15:0]  boff;
    logic [31:0]         grant;

    assign lg_eff    = (lg_reg > 5'(MAX_LOG)) ? 5'(MAX_LOG) : lg_reg;
    assign mask      = 17'((18'd1 << lg_eff) - 18'd1);
    assign units_sum = {2'b00, len_reg} + 33'(hdr_reg) + 33'(mask);
    assign units_calc = units_sum >> lg_eff;

    assign off    = addr_reg - 32'(hdr_reg);
    assign unit32 = off >> lg_eff;
    assign rel_ok_calc = (addr_reg >= 32'(hdr_reg)) && ((off & 32'(mask)) == 32'd0)
                         && (unit32 < 32'(UNITS));

    // ceiling log2 of the unit count
    assign um1 = units_reg - 33'd1;
    always_comb begin
        kk = 6'd0;
        for (int i = 0; i < 33; i++) begin
            if (um1[i]) kk = 6'(i + 1);
        end
        if (units_reg <= 33'd1) kk = 6'd0;
    end

    assign e         = entry_t'(rdata);
    assign scan_next = scan_reg + ((UNIT_W+1)'(1) << e.order);
    assign cand      = e.free && (e.order >= k_reg)
                       && (!found_reg || (e.order < best_ord_reg));
    assign new_ord   = best_ord_reg - 5'd1;
    assign upper     = best_reg + (UNIT_W'(1) << new_ord);
    assign obit      = UNIT_W'(1) << o_reg;
    assign boff      = (UNIT_W+16)'(best_reg) << lg_eff;
    assign grant     = 32'(boff) + 32'(hdr_reg);

    // table write and read selection
    always_comb begin
        we     = 1'b0;
        waddr  = u_reg;
        wentry = '0;
        priority if (cmd.clr_step) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            if (clr_cnt_reg == '0) wentry = '{head: 1'b1, free: 1'b1,
                                              order: 5'(MAX_ORDER)};
        end else if (cmd.split) begin
            we     = 1'b1;
            waddr  = upper;
            wentry = '{head: 1'b1, free: 1'b1, order: new_ord};
        end else if (cmd.mark) begin
            we     = 1'b1;
            waddr  = best_reg;
            wentry = '{head: 1'b1, free: 1'b0, order: k_reg};
        end else if (cmd.bud_chk) begin
            we    = 1'b1;
            waddr = u_reg | obit;
        end else if (cmd.rel_wr) begin
            we     = 1'b1;
            wentry = '{head: 1'b1, free: 1'b1, order: o_reg};
        end
    end

    always_comb begin
        priority if (cmd.scan_rd) begin
            raddr = scan_reg[UNIT_W-1:0];
        end else if (cmd.bud_rd) begin
            raddr = u_reg ^ obit;
        end else begin
            raddr = u_reg;
        end
    end

    bba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (UNITS)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (ENTRY_W'(wentry)),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lg_reg      <= RST_MIN_LOG;
            hdr_reg     <= RST_HDR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && (cfg_index == CFG_MIN_LOG)) lg_reg  <= cfg_data[4:0];
            if (cfg_valid && (cfg_index == CFG_HDR))     hdr_reg <= cfg_data[6:0];
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + UNIT_W'(1);
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg  <= s_action;
            len_reg  <= s_request_length;
            addr_reg <= s_release_address;
        end
        if (cmd.prep) begin
            units_reg       <= units_calc;
            rel_ok_reg      <= rel_ok_calc;
            u_reg           <= unit32[UNIT_W-1:0];
            pend_status_reg <= 1'b0;
            pend_addr_reg   <= 32'd0;
        end
        if (cmd.order) begin
            k_reg    <= 5'(kk);
            fail_reg <= units_reg > 33'(UNITS);
        end
        if (cmd.set_fail) pend_status_reg <= 1'b1;
        if (cmd.scan_init) begin
            scan_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_chk) begin
            scan_reg <= scan_next;
            if (cand) begin
                found_reg    <= 1'b1;
                best_reg     <= scan_reg[UNIT_W-1:0];
                best_ord_reg <= e.order;
            end
        end
        if (cmd.split) best_ord_reg <= new_ord;
        if (cmd.mark) pend_addr_reg <= grant;
        if (cmd.rel_chk) o_reg <= (e.order > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : e.order;
        if (cmd.bud_chk) begin
            u_reg <= u_reg & ~obit;
            o_reg <= o_reg + 5'd1;
        end
        if (cmd.out_load) begin
            m_status_reg <= pend_status_reg;
            m_addr_reg   <= pend_addr_reg;
        end
    end

    always_comb begin
        sts            = '0;
        sts.clr_last   = (clr_cnt_reg == UNIT_W'(UNITS - 1));
        sts.act_rel    = act_reg;
        sts.fail       = fail_reg;
        sts.rel_ok     = rel_ok_reg;
        sts.scan_end   = scan_next[UNIT_W];
        sts.found_now  = found_reg || cand;
        sts.split_more = best_ord_reg > k_reg;
        sts.rel_live   = e.head && !e.free;
        sts.o_max      = o_reg >= 5'(MAX_ORDER);
        sts.merge      = e.head && e.free && (e.order == o_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_addr_reg;

endmodule

`default_nettype wire

// File: rtl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp (and bba_ram through bba_dp).
//
// Usage
//  - Request channel s_*: s_action 0 allocates s_request_length bytes (plus
//    the header), 1 releases the block whose user offset is s_release_address.
//  - Result channel m_*: one result per request; m_status 1 means no block
//    large enough, m_granted_address is the user offset (zero on release/fail).
//  - Config channel cfg_*: index 0 min block log2, index 1 header bytes.
//    Always ready; write only while no request is in progress.
//  - Allocate: the scan reads each block in the table once, then splits the
//    found block; too large a request skips the scan. Release merges free
//    buddies; an ignored one does not. One write and one read table port.
//  - One request is worked on at a time; the next is taken once the result
//    sits in the output register, even while the receiver has not taken it.
//  - Reset: synchronous, active low. Afterwards all 2^MAX_ORDER (1024) table
//    entries are cleared with s_ready low; config writes are taken.
//  - Receiver stall: the result holds in the output register; a finished
//    second request waits in its last state until the register frees.
`default_nettype none

module buddy_block_allocator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [30:0] s_request_length,
    input  wire logic [31:0] s_release_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [31:0]      m_granted_address,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import bba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // config registers take a write in any cycle
    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_action          (s_action),
        .s_request_length  (s_request_length),
        .s_release_address (s_release_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

endmodule

`default_nettype wire
